// File: rtl/shared_pool_multi_queue_defines.svh
// Assertion macros used by the queue pool datapath.
`ifndef SHARED_POOL_MULTI_QUEUE_DEFINES_SVH
`define SHARED_POOL_MULTI_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define SPMQ_ASSERT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spmq assertion failed");
`define SPMQ_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spmq assertion failed");
`else
`define SPMQ_ASSERT(name, clk, rst, ante, cons)
`define SPMQ_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

// File: rtl/spmq_pkg.sv
// Shared constants and control types for the queue pool.
package spmq_pkg;

   localparam int DEF_NUM_QUEUES = 16;
   localparam int DEF_NUM_CHUNKS = 128;
   localparam int DEF_CHUNK_LEN  = 15;

   localparam int QID_W    = 4;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int LINK_W   = 8;

   localparam logic [LINK_W-1:0] LINK_NONE = 8'd255;

   localparam logic OP_PUT = 1'b0;
   localparam logic OP_GET = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_POOL_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUE_EMPTY = 2'd2;

   typedef struct packed {
      logic load_item;
      logic put_fail;
      logic put_direct;
      logic put_alloc_rd;
      logic put_link;
      logic put_finish;
      logic get_fail;
      logic get_link_rd;
      logic get_data_rd;
      logic get_adv;
      logic get_finish;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic bad_queue;
      logic queue_empty;
      logic need_chunk;
      logic pool_empty;
      logic head_spent;
      logic out_free;
   } stat_type;

endpackage

// File: rtl/spmq_if.sv
// Request and response channel interfaces of the queue pool.
interface spmq_req_if import spmq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [QID_W-1:0]  queue_id;
   logic [BYTE_W-1:0] put_byte;

   modport source (output valid, opcode, queue_id, put_byte, input ready);
   modport sink   (input valid, opcode, queue_id, put_byte, output ready);
endinterface

interface spmq_rsp_if import spmq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   get_byte;
   logic [STATUS_W-1:0] status;
   logic                now_empty;

   modport source (output valid, get_byte, status, now_empty, input ready);
   modport sink   (input valid, get_byte, status, now_empty, output ready);
endinterface

// File: rtl/spmq_ctrl.sv
// Operation sequencer of the queue pool.
module spmq_ctrl import spmq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EXEC     = 3'd1;
   localparam logic [2:0] S_PUT_LINK = 3'd2;
   localparam logic [2:0] S_PUT_NONE = 3'd3;
   localparam logic [2:0] S_GET_LINK = 3'd4;
   localparam logic [2:0] S_GET_DATA = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.op == OP_PUT) begin
               if (stat.bad_queue || (stat.need_chunk && stat.pool_empty)) begin
                  if (stat.out_free) begin
                     cmd.put_fail = 1'b1;
                     state_in     = S_IDLE;
                  end
               end else if (stat.need_chunk) begin
                  cmd.put_alloc_rd = 1'b1;
                  state_in         = S_PUT_LINK;
               end else if (stat.out_free) begin
                  cmd.put_direct = 1'b1;
                  state_in       = S_IDLE;
               end
            end else begin
               if (stat.bad_queue || stat.queue_empty) begin
                  if (stat.out_free) begin
                     cmd.get_fail = 1'b1;
                     state_in     = S_IDLE;
                  end
               end else if (stat.head_spent) begin
                  cmd.get_link_rd = 1'b1;
                  state_in        = S_GET_LINK;
               end else begin
                  cmd.get_data_rd = 1'b1;
                  state_in        = S_GET_DATA;
               end
            end
         end
         S_PUT_LINK: begin
            cmd.put_link = 1'b1;
            state_in     = S_PUT_NONE;
         end
         S_PUT_NONE: begin
            if (stat.out_free) begin
               cmd.put_finish = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_GET_LINK: begin
            cmd.get_adv = 1'b1;
            state_in    = S_GET_DATA;
         end
         S_GET_DATA: begin
            if (stat.out_free) begin
               cmd.get_finish = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/spmq_datapath.sv
// Chunk pool, link memory, free list, per-queue pointers and response register.
`include "shared_pool_multi_queue_defines.svh"

module spmq_datapath import spmq_pkg::*; #(
   parameter int NUM_QUEUES = DEF_NUM_QUEUES,
   parameter int NUM_CHUNKS = DEF_NUM_CHUNKS,
   parameter int CHUNK_LEN  = DEF_CHUNK_LEN
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_opcode,
   input  logic [QID_W-1:0]    req_queue_id,
   input  logic [BYTE_W-1:0]   req_put_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_get_byte,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_now_empty,
   input  cmd_type             cmd,
   output stat_type            stat
);

   localparam int QIW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int CIW   = $clog2(NUM_CHUNKS);
   localparam int PW    = $clog2(CHUNK_LEN + 1);
   localparam int DEPTH = NUM_CHUNKS * CHUNK_LEN;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [LINK_W-1:0] CHUNK_LIMIT = LINK_W'(NUM_CHUNKS);
   localparam logic [PW-1:0]     LEN_P       = PW'(CHUNK_LEN);

   function automatic logic [CIW-1:0] chunk_ok(input logic [LINK_W-1:0] v);
      return (v < CHUNK_LIMIT) ? v[CIW-1:0] : '0;
   endfunction

   function automatic logic [LINK_W-1:0] link_reset_val(input logic [CIW-1:0] a);
      return (a == '0) ? LINK_NONE : (LINK_W'(a) - LINK_W'(1));
   endfunction

   function automatic logic [AW-1:0] slot(input logic [CIW-1:0] c, input logic [PW-1:0] p);
      logic [PW-1:0] pp;
      pp = (p >= LEN_P) ? '0 : p;
      return AW'(c) * AW'(CHUNK_LEN) + AW'(pp);
   endfunction

   // latched item
   logic              op_ff;
   logic              bad_ff;
   logic [QIW-1:0]    q_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [QIW+QID_W-1:0] q_wide;

   // per-queue state
   logic [NUM_QUEUES-1:0] empty_ff;
   logic [CIW-1:0]        head_chunk_ff [NUM_QUEUES];
   logic [PW-1:0]         head_pos_ff   [NUM_QUEUES];
   logic [CIW-1:0]        tail_chunk_ff [NUM_QUEUES];
   logic [PW-1:0]         tail_pos_ff   [NUM_QUEUES];

   // free list and links
   logic [LINK_W-1:0]     free_head_ff;
   logic [LINK_W-1:0]     free_head_in;
   logic [LINK_W-1:0]     link_mem [NUM_CHUNKS];
   logic [NUM_CHUNKS-1:0] link_valid_ff;
   logic [LINK_W-1:0]     link_q_ff;
   logic [CIW-1:0]        link_raddr_ff;

   // chunk data
   logic [BYTE_W-1:0] byte_mem [DEPTH];
   logic [BYTE_W-1:0] byte_q_ff;

   // walk position
   logic [CIW-1:0] cur_h_ff;
   logic [CIW-1:0] cur_h_in;
   logic [PW-1:0]  cur_p_ff;
   logic [PW-1:0]  cur_p_in;

   // response register
   logic                rsp_valid_ff;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_empty_ff;

   logic                q_empty;
   logic [CIW-1:0]      head_c;
   logic [PW-1:0]       head_p;
   logic [CIW-1:0]      tail_c;
   logic [PW-1:0]       tail_p;
   logic [LINK_W-1:0]   link_val;
   logic [PW-1:0]       p_next;
   logic                drain;

   logic                link_we;
   logic [CIW-1:0]      link_waddr;
   logic [LINK_W-1:0]   link_wdata;
   logic                link_re;
   logic [CIW-1:0]      link_raddr;
   logic                byte_we;
   logic [AW-1:0]       byte_waddr;
   logic                byte_re;
   logic [AW-1:0]       byte_raddr;
   logic                head_we;
   logic [CIW-1:0]      head_chunk_in;
   logic [PW-1:0]       head_pos_in;
   logic                tail_we;
   logic [CIW-1:0]      tail_chunk_in;
   logic [PW-1:0]       tail_pos_in;
   logic                empty_we;
   logic                empty_in;
   logic                resp_we;
   logic [BYTE_W-1:0]   resp_byte_in;
   logic [STATUS_W-1:0] resp_status_in;
   logic                resp_empty_in;
   logic [3:0]          resp_cmds;

   assign q_wide   = {QIW'(0), req_queue_id};
   assign q_empty  = empty_ff[q_ff];
   assign head_c   = head_chunk_ff[q_ff];
   assign head_p   = head_pos_ff[q_ff];
   assign tail_c   = tail_chunk_ff[q_ff];
   assign tail_p   = tail_pos_ff[q_ff];
   assign link_val = link_valid_ff[link_raddr_ff] ? link_q_ff : link_reset_val(link_raddr_ff);
   assign p_next   = cur_p_ff + PW'(1);
   assign drain    = (cur_h_ff == tail_c) && (p_next == tail_p);

   assign stat.op          = op_ff;
   assign stat.bad_queue   = bad_ff;
   assign stat.queue_empty = q_empty;
   assign stat.need_chunk  = q_empty || (tail_p >= LEN_P);
   assign stat.pool_empty  = (free_head_ff == LINK_NONE);
   assign stat.head_spent  = (head_p >= LEN_P);
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   assign resp_cmds = {cmd.put_fail || cmd.put_direct, cmd.put_finish, cmd.get_fail,
                       cmd.get_finish};

   always_comb begin
      free_head_in   = free_head_ff;
      cur_h_in       = cur_h_ff;
      cur_p_in       = cur_p_ff;
      link_we        = 1'b0;
      link_waddr     = cur_h_ff;
      link_wdata     = LINK_NONE;
      link_re        = 1'b0;
      link_raddr     = head_c;
      byte_we        = 1'b0;
      byte_waddr     = slot(tail_c, tail_p);
      byte_re        = 1'b0;
      byte_raddr     = slot(head_c, head_p);
      head_we        = 1'b0;
      head_chunk_in  = cur_h_ff;
      head_pos_in    = p_next;
      tail_we        = 1'b0;
      tail_chunk_in  = tail_c;
      tail_pos_in    = tail_p + PW'(1);
      empty_we       = 1'b0;
      empty_in       = 1'b0;
      resp_we        = 1'b0;
      resp_byte_in   = '0;
      resp_status_in = ST_OK;
      resp_empty_in  = 1'b0;
      if (cmd.put_fail) begin
         resp_we        = 1'b1;
         resp_status_in = ST_POOL_EMPTY;
         resp_empty_in  = bad_ff || q_empty;
      end else if (cmd.put_direct) begin
         byte_we = 1'b1;
         tail_we = 1'b1;
         resp_we = 1'b1;
      end else if (cmd.put_alloc_rd) begin
         link_re    = 1'b1;
         link_raddr = chunk_ok(free_head_ff);
         cur_h_in   = chunk_ok(free_head_ff);
      end else if (cmd.put_link) begin
         free_head_in = link_val;
         if (!q_empty) begin
            link_we    = 1'b1;
            link_waddr = tail_c;
            link_wdata = LINK_W'(cur_h_ff);
         end else begin
            head_we       = 1'b1;
            head_chunk_in = cur_h_ff;
            head_pos_in   = '0;
         end
         tail_we       = 1'b1;
         tail_chunk_in = cur_h_ff;
         tail_pos_in   = PW'(1);
         empty_we      = 1'b1;
         empty_in      = 1'b0;
         byte_we       = 1'b1;
         byte_waddr    = slot(cur_h_ff, '0);
      end else if (cmd.put_finish) begin
         link_we    = 1'b1;
         link_waddr = cur_h_ff;
         link_wdata = LINK_NONE;
         resp_we    = 1'b1;
      end else if (cmd.get_fail) begin
         resp_we        = 1'b1;
         resp_status_in = ST_QUEUE_EMPTY;
         resp_empty_in  = 1'b1;
      end else if (cmd.get_link_rd) begin
         link_re    = 1'b1;
         link_raddr = head_c;
         cur_h_in   = head_c;
      end else if (cmd.get_data_rd) begin
         byte_re    = 1'b1;
         byte_raddr = slot(head_c, head_p);
         cur_h_in   = head_c;
         cur_p_in   = head_p;
      end else if (cmd.get_adv) begin
         link_we      = 1'b1;
         link_waddr   = cur_h_ff;
         link_wdata   = free_head_ff;
         free_head_in = LINK_W'(cur_h_ff);
         cur_h_in     = chunk_ok(link_val);
         cur_p_in     = '0;
         byte_re      = 1'b1;
         byte_raddr   = slot(chunk_ok(link_val), '0);
      end else if (cmd.get_finish) begin
         head_we       = 1'b1;
         head_chunk_in = cur_h_ff;
         head_pos_in   = p_next;
         if (drain) begin
            link_we      = 1'b1;
            link_waddr   = cur_h_ff;
            link_wdata   = free_head_ff;
            free_head_in = LINK_W'(cur_h_ff);
            empty_we     = 1'b1;
            empty_in     = 1'b1;
         end
         resp_we       = 1'b1;
         resp_byte_in  = byte_q_ff;
         resp_empty_in = drain;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff      <= '1;
         free_head_ff  <= LINK_W'(NUM_CHUNKS - 1);
         link_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (empty_we) begin
            empty_ff[q_ff] <= empty_in;
         end
         free_head_ff <= free_head_in;
         if (link_we) begin
            link_valid_ff[link_waddr] <= 1'b1;
         end
         if (resp_we) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= req_opcode;
         bad_ff  <= (32'(req_queue_id) >= 32'(NUM_QUEUES));
         q_ff    <= q_wide[QIW-1:0];
         byte_ff <= req_put_byte;
      end
      if (head_we) begin
         head_chunk_ff[q_ff] <= head_chunk_in;
         head_pos_ff[q_ff]   <= head_pos_in;
      end
      if (tail_we) begin
         tail_chunk_ff[q_ff] <= tail_chunk_in;
         tail_pos_ff[q_ff]   <= tail_pos_in;
      end
      cur_h_ff <= cur_h_in;
      cur_p_ff <= cur_p_in;
      if (resp_we) begin
         rsp_byte_ff   <= resp_byte_in;
         rsp_status_ff <= resp_status_in;
         rsp_empty_ff  <= resp_empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_q_ff     <= link_mem[link_raddr];
         link_raddr_ff <= link_raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_mem[byte_waddr] <= byte_ff;
      end
      if (byte_re) begin
         byte_q_ff <= byte_mem[byte_raddr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_get_byte  = rsp_byte_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_now_empty = rsp_empty_ff;

   `SPMQ_ASSERT(a_free_head_range, clock, reset, 1'b1, (free_head_ff == LINK_NONE) || (free_head_ff < CHUNK_LIMIT))
   `SPMQ_ASSERT(a_alloc_has_chunk, clock, reset, cmd.put_alloc_rd, free_head_ff != LINK_NONE)
   `SPMQ_ASSERT(a_get_live_queue, clock, reset, cmd.get_finish, !bad_ff && !q_empty)
   `SPMQ_ASSERT(a_one_beat, clock, reset, 1'b1, $onehot0(resp_cmds))
   `SPMQ_ASSERT_NXT(a_beat_lands, clock, reset, resp_we, rsp_valid_ff)

endmodule

// File: rtl/shared_pool_multi_queue.sv
// Top level of the shared chunk pool multi-queue byte FIFO.
// NUM_QUEUES byte FIFOs share NUM_CHUNKS chunks of CHUNK_LEN bytes, chained
// through a link memory with a free list; one request beat (put or get on a
// queue) yields one response beat (byte, status, queue-empty flag). Items are
// handled one at a time, in steps set by the single-port link and data memories
// with registered reads. A put that opens a chunk reads the free-list link, then
// links the chunk and stores the byte, then ends its link; a get reads its byte,
// after a link read if it enters the next chunk; other puts and failed items reply
// from the execute state. A response waiting on the output register stalls only
// the item that needs to deliver next. No clearing pass follows reset: link
// entries carry valid bits, and chunk data is never read before it is written.
module shared_pool_multi_queue import spmq_pkg::*; #(
   parameter int NUM_QUEUES = DEF_NUM_QUEUES,
   parameter int NUM_CHUNKS = DEF_NUM_CHUNKS,
   parameter int CHUNK_LEN  = DEF_CHUNK_LEN
) (
   input logic          clock,
   input logic          reset,
   spmq_req_if.sink     req_chan,
   spmq_rsp_if.source   rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   spmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spmq_datapath #(
      .NUM_QUEUES (NUM_QUEUES),
      .NUM_CHUNKS (NUM_CHUNKS),
      .CHUNK_LEN  (CHUNK_LEN)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_opcode    (req_chan.opcode),
      .req_queue_id  (req_chan.queue_id),
      .req_put_byte  (req_chan.put_byte),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_get_byte  (rsp_chan.get_byte),
      .rsp_status    (rsp_chan.status),
      .rsp_now_empty (rsp_chan.now_empty),
      .cmd           (cmd),
      .stat          (stat)
   );

endmodule

// File: tb/sv/tb.sv
// Testbench for the shared chunk pool multi-queue: predicts every reply and checks it.
`timescale 1ns / 1ps
module tb;
   import spmq_pkg::*;

   localparam int NQ          = DEF_NUM_QUEUES;
   localparam int NCHUNK      = DEF_NUM_CHUNKS;
   localparam int CLEN        = DEF_CHUNK_LEN;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [BYTE_W-1:0]   get_byte;
      logic [STATUS_W-1:0] status;
      logic                now_empty;
   } reply_type;

   class byte_queue_tracker;
      logic [BYTE_W-1:0] chunk_data [NCHUNK*CLEN];
      logic [LINK_W-1:0] chunk_next [NCHUNK];
      logic [LINK_W-1:0] free_top;
      logic [NQ-1:0]     q_empty;
      int                head_chunk [NQ];
      int                head_pos [NQ];
      int                tail_chunk [NQ];
      int                tail_pos [NQ];
      reply_type         owed_replies [$];
      int                fail_count;
      int                reply_count;
      int                put_count;
      int                get_count;
      int                drop_count;
      int                empty_get_count;

      function new();
         for (int i = 0; i < NCHUNK; i++)
            chunk_next[i] = (i == 0) ? LINK_NONE : LINK_W'(i - 1);
         free_top = LINK_W'(NCHUNK - 1);
         q_empty = '1;
         for (int i = 0; i < NQ; i++) begin
            head_chunk[i] = 0;
            head_pos[i] = 0;
            tail_chunk[i] = 0;
            tail_pos[i] = 0;
         end
      endfunction

      function void free_chunk(int c);
         chunk_next[c] = free_top;
         free_top = LINK_W'(c);
      endfunction

      function void record_request(logic op, logic [QID_W-1:0] qid, logic [BYTE_W-1:0] val);
         reply_type r;
         int c, h, p;
         r = '0;
         r.status = ST_OK;
         if (op == OP_PUT) begin
            put_count++;
            if (q_empty[qid] || tail_pos[qid] >= CLEN) begin
               if (free_top == LINK_NONE) begin
                  r.status = ST_POOL_EMPTY;
                  drop_count++;
               end else begin
                  c = free_top;
                  free_top = chunk_next[c];
                  if (q_empty[qid]) begin
                     head_chunk[qid] = c;
                     head_pos[qid] = 0;
                  end else begin
                     chunk_next[tail_chunk[qid]] = LINK_W'(c);
                  end
                  tail_chunk[qid] = c;
                  tail_pos[qid] = 0;
                  chunk_next[c] = LINK_NONE;
                  q_empty[qid] = 1'b0;
               end
            end
            if (r.status == ST_OK) begin
               chunk_data[tail_chunk[qid]*CLEN + tail_pos[qid]] = val;
               tail_pos[qid]++;
            end
         end else begin
            get_count++;
            if (q_empty[qid]) begin
               r.status = ST_QUEUE_EMPTY;
               empty_get_count++;
            end else begin
               h = head_chunk[qid];
               p = head_pos[qid];
               if (p >= CLEN) begin
                  c = chunk_next[h];
                  free_chunk(h);
                  h = c;
                  p = 0;
               end
               r.get_byte = chunk_data[h*CLEN + p];
               p++;
               if (h == tail_chunk[qid] && p == tail_pos[qid]) begin
                  free_chunk(h);
                  q_empty[qid] = 1'b1;
               end
               head_chunk[qid] = h;
               head_pos[qid] = p;
            end
         end
         r.now_empty = q_empty[qid];
         owed_replies.push_back(r);
      endfunction

      function void check_reply(reply_type got);
         reply_type want;
         reply_count++;
         if (owed_replies.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("reply %0d with none pending: byte %0h status %0d empty %0b",
                        reply_count, got.get_byte, got.status, got.now_empty);
            return;
         end
         want = owed_replies.pop_front();
         if (got.get_byte !== want.get_byte || got.status !== want.status ||
             got.now_empty !== want.now_empty) begin
            fail_count++;
            if (fail_count <= 10)
               $display({"reply %0d mismatch: byte %0h/%0h status %0d/%0d ",
                         "empty %0b/%0b (exp/act)"},
                        reply_count, want.get_byte, got.get_byte, want.status, got.status,
                        want.now_empty, got.now_empty);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic hold_armed;
   int   cycle_count;
   int   send_idle_pct;
   int   recv_idle_pct;
   byte_queue_tracker tracker;

   spmq_req_if req_bus ();
   spmq_rsp_if rsp_bus ();

   shared_pool_multi_queue u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      bit hold_done;
      int hold_left;
      hold_done = 1'b0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** shared_pool_multi_queue: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_reply('{rsp_bus.get_byte, rsp_bus.status, rsp_bus.now_empty});
   end

   task automatic send_item(input logic op, input logic [QID_W-1:0] qid,
                            input logic [BYTE_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.opcode = op;
      req_bus.queue_id = qid;
      req_bus.put_byte = val;
      do @(posedge clock); while (!req_bus.ready);
      tracker.record_request(op, qid, val);
      @(negedge clock);
   endtask

   task automatic send_mix(input int count, input int put_pct, input int qlo, input int qhi);
      for (int i = 0; i < count; i++)
         send_item(($urandom_range(99) < put_pct) ? OP_PUT : OP_GET,
                   QID_W'($urandom_range(qhi, qlo)), BYTE_W'($urandom_range(255)));
   endtask

   initial begin
      int guard;
      tracker = new();
      hold_armed = 1'b0;
      send_idle_pct = 24;
      recv_idle_pct = 24;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_PUT;
      req_bus.queue_id = '0;
      req_bus.put_byte = '0;
      reset = 1'b1;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // directed: empty gets, field extremes, a chunk boundary crossed and drained
      send_item(OP_GET, 4'd0, 8'h00);
      send_item(OP_GET, 4'd15, 8'hff);
      send_item(OP_PUT, 4'd0, 8'h00);
      send_item(OP_PUT, 4'd15, 8'hff);
      send_item(OP_GET, 4'd0, 8'h5a);
      send_item(OP_GET, 4'd15, 8'ha5);
      for (int i = 0; i < 16; i++)
         send_item(OP_PUT, 4'd9, BYTE_W'(8'h80 + i));
      repeat (16) send_item(OP_GET, 4'd9, 8'h00);

      // fill the pool until puts get dropped; stall the receiver early on
      guard = 0;
      while (tracker.drop_count < 6 && guard < 2400) begin
         if (guard == 50)
            hold_armed = 1'b1;
         send_idle_pct = (guard >= 600 && guard < 1200) ? 0 : 24;
         recv_idle_pct = send_idle_pct;
         send_item(OP_PUT, QID_W'($urandom_range(NQ - 1)), BYTE_W'($urandom_range(255)));
         guard++;
      end
      send_idle_pct = 24;
      recv_idle_pct = 24;

      // release chunks on two queues, then reuse them from anywhere
      send_mix(50, 35, 0, 1);
      send_mix(30, 50, 0, NQ - 1);
      req_bus.valid = 1'b0;

      while (tracker.owed_replies.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d puts (%0d dropped on a full pool), %0d gets (%0d on empty queues)",
               tracker.put_count, tracker.drop_count, tracker.get_count,
               tracker.empty_get_count);
      $display("%0d replies checked, %0d mismatches, %0d cycles",
               tracker.reply_count, tracker.fail_count, cycle_count);
      if (tracker.fail_count == 0 && tracker.owed_replies.size() == 0)
         $display("** shared_pool_multi_queue: PASSED **");
      else
         $display("** shared_pool_multi_queue: FAILED **");
      $finish;
   end
endmodule

// File: sim.f
+incdir+rtl
rtl/spmq_pkg.sv
rtl/spmq_if.sv
rtl/spmq_ctrl.sv
rtl/spmq_datapath.sv
rtl/shared_pool_multi_queue.sv
tb/sv/tb.sv
